/* rtl/ntsb_pkg.sv */
`timescale 1ns / 1ps

package ntsb_pkg;

    // Ring capacity in samples
    localparam int BUFFER_DEPTH = 64;

    localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int STAMP_W      = 63;
    localparam int WORD_W       = 32;
    localparam int MOTION_WORDS = 6;
    localparam int MOTION_W     = MOTION_WORDS * WORD_W;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [WORD_W-1:0]  word_t;

    typedef struct packed {
        logic   kind;
        stamp_t sample_stamp;
        word_t  pos_x_in;
        word_t  pos_y_in;
        word_t  pos_z_in;
        word_t  vel_x_in;
        word_t  vel_y_in;
        word_t  vel_z_in;
        stamp_t query_time;
    } req_t;

    typedef struct packed {
        logic   found;
        stamp_t match_stamp;
        word_t  pos_x_out;
        word_t  pos_y_out;
        word_t  pos_z_out;
        word_t  vel_x_out;
        word_t  vel_y_out;
        word_t  vel_z_out;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_DONE
    } state_t;

    // Add two ring positions, wrap at the ring depth
    function automatic idx_t wrap_add(input idx_t a, input idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W + 1)'(BUFFER_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(BUFFER_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Absolute difference of two stamps
    function automatic stamp_t abs_diff(input stamp_t a, input stamp_t b);
        logic [STAMP_W:0] d_ab;
        logic [STAMP_W:0] d_ba;
        d_ab = {1'b0, a} - {1'b0, b};
        d_ba = {1'b0, b} - {1'b0, a};
        return d_ab[STAMP_W] ? d_ba[STAMP_W-1:0] : d_ab[STAMP_W-1:0];
    endfunction

endpackage

/* rtl/ntsb_ram.sv */
`timescale 1ns / 1ps

module ntsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/nearest_timestamp_sample_buffer_top.sv */
`timescale 1ns / 1ps

// Nearest-timestamp sample buffer.
// Request channel (req_valid / req_stall / req_data): kind selects store or query.
// A store writes the stamp and six motion words into the ring in the cycle it is
// accepted, overwriting the oldest sample once the ring is full; it gives no response.
// A query scans the held samples oldest to newest through one stamp memory read
// port and one shared absolute-difference / compare unit, one sample per cycle,
// and keeps the oldest of equally near samples.
// Response channel (rsp_valid / rsp_stall / rsp_data) carries one response per
// query; found is low with zeroed fields when the ring is empty.
// A store is written on acceptance; a query's response follows the scan, the
// memory read, difference and compare stages and the final row fetch (a query
// on an empty ring goes straight to the response).
// A query holds the request channel until its response is loaded into the output
// register; a store does not hold it.
// req_stall is high while a query is in progress. A stalled response is held in
// the output register; a query that finishes meanwhile waits for it to drain.
// Reset empties the ring and drops any pending response; memory contents
// are not cleared, held entries are tracked by the fill count alone.
module nearest_timestamp_sample_buffer_top
    import ntsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    state_t state_reg, state_next;

    // Ring bookkeeping
    idx_t   oldest_reg, oldest_next;
    cnt_t   count_reg, count_next;

    // Scan sequencer
    idx_t   scan_ptr_reg, scan_ptr_next;
    cnt_t   left_reg, left_next;
    stamp_t target_reg, target_next;
    logic   found_reg, found_next;

    // Read-return stage
    logic   rd_vld_reg, rd_vld_next;
    idx_t   rd_slot_reg, rd_slot_next;
    logic   rd_first_reg, rd_first_next;

    // Difference stage
    logic   dt_vld_reg, dt_vld_next;
    stamp_t dt_reg, dt_next;
    idx_t   dt_slot_reg, dt_slot_next;
    logic   dt_first_reg, dt_first_next;

    // Best match so far
    stamp_t best_dt_reg, best_dt_next;
    idx_t   best_slot_reg, best_slot_next;

    // Output register
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_data_reg, rsp_data_next;

    logic   store_we;
    logic   query_go;
    logic   scan_issue;
    logic   load_rsp;
    logic   rsp_free;
    logic   ring_full;
    idx_t   wslot;
    idx_t   stamp_raddr;
    stamp_t stamp_rdata;
    logic [MOTION_W-1:0] motion_wdata;
    logic [MOTION_W-1:0] motion_rdata;

    ntsb_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (wslot),
        .wdata (req_data.sample_stamp),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    ntsb_ram #(
        .WIDTH (MOTION_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_motion_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (wslot),
        .wdata (motion_wdata),
        .raddr (best_slot_reg),
        .rdata (motion_rdata)
    );

    assign motion_wdata = {req_data.pos_x_in, req_data.pos_y_in, req_data.pos_z_in,
                           req_data.vel_x_in, req_data.vel_y_in, req_data.vel_z_in};

    assign ring_full = (count_reg == CNT_W'(BUFFER_DEPTH));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Append after the newest sample, or overwrite the oldest once full
    assign wslot = ring_full ? oldest_reg : wrap_add(oldest_reg, count_reg[IDX_W-1:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req_data.kind == KIND_QUERY))
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !dt_vld_reg)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_stall   = (state_reg != ST_IDLE);
        store_we    = 1'b0;
        query_go    = 1'b0;
        scan_issue  = 1'b0;
        load_rsp    = 1'b0;
        stamp_raddr = best_slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                store_we = req_valid && (req_data.kind == KIND_STORE);
                query_go = req_valid && (req_data.kind == KIND_QUERY);
            end
            ST_SCAN:
            begin
                scan_issue  = 1'b1;
                stamp_raddr = scan_ptr_reg;
            end
            ST_DONE:
            begin
                load_rsp = rsp_free;
            end
            default:
            begin
                stamp_raddr = best_slot_reg;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        left_next      = left_reg;
        target_next    = target_reg;
        found_next     = found_reg;
        best_dt_next   = best_dt_reg;
        best_slot_next = best_slot_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        // Advance the ring on a store
        if (store_we)
        begin
            if (ring_full)
            begin
                oldest_next = wrap_add(oldest_reg, idx_t'(1));
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Start the scan at the oldest sample
        if (query_go)
        begin
            scan_ptr_next = oldest_reg;
            left_next     = count_reg;
            target_next   = req_data.query_time;
            found_next    = (count_reg != '0);
        end

        if (scan_issue)
        begin
            scan_ptr_next = wrap_add(scan_ptr_reg, idx_t'(1));
            left_next     = left_reg - CNT_W'(1);
        end

        rd_vld_next   = scan_issue;
        rd_slot_next  = scan_ptr_reg;
        rd_first_next = scan_issue && (left_reg == count_reg);

        dt_vld_next   = rd_vld_reg;
        dt_next       = abs_diff(stamp_rdata, target_reg);
        dt_slot_next  = rd_slot_reg;
        dt_first_next = rd_first_reg;

        // Strictly nearer only, so the older sample keeps a tie
        if (dt_vld_reg && (dt_first_reg || (dt_reg < best_dt_reg)))
        begin
            best_dt_next   = dt_reg;
            best_slot_next = dt_slot_reg;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
            if (found_reg)
            begin
                rsp_data_next.found       = 1'b1;
                rsp_data_next.match_stamp = stamp_rdata;
                rsp_data_next.pos_x_out   = motion_rdata[6*WORD_W-1 -: WORD_W];
                rsp_data_next.pos_y_out   = motion_rdata[5*WORD_W-1 -: WORD_W];
                rsp_data_next.pos_z_out   = motion_rdata[4*WORD_W-1 -: WORD_W];
                rsp_data_next.vel_x_out   = motion_rdata[3*WORD_W-1 -: WORD_W];
                rsp_data_next.vel_y_out   = motion_rdata[2*WORD_W-1 -: WORD_W];
                rsp_data_next.vel_z_out   = motion_rdata[WORD_W-1:0];
            end
            else
            begin
                rsp_data_next = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            dt_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            dt_vld_reg    <= dt_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        scan_ptr_reg  <= scan_ptr_next;
        left_reg      <= left_next;
        target_reg    <= target_next;
        found_reg     <= found_next;
        rd_slot_reg   <= rd_slot_next;
        rd_first_reg  <= rd_first_next;
        dt_reg        <= dt_next;
        dt_slot_reg   <= dt_slot_next;
        dt_first_reg  <= dt_first_next;
        best_dt_reg   <= best_dt_next;
        best_slot_reg <= best_slot_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Fill count never passes the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond ring depth");

    // A response is only raised from the final sequencer state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside final state");

    // A store into a full ring moves the oldest pointer and keeps the count
    a_full_store: assert property (@(posedge clk) disable iff (!rst_n)
        (store_we && ring_full) |=> ($stable(count_reg) && (oldest_reg != $past(oldest_reg)
            || BUFFER_DEPTH == 1)))
        else $error("full-ring store did not retire the oldest sample");

    // The scan pipeline is empty whenever the block takes a request
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !dt_vld_reg))
        else $error("scan pipeline busy while idle");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import ntsb_pkg::*;
();

    // Run bounds: query time grows with the ring depth, and receiver stall runs and
    // sender gaps are bounded by the driver and receiver settings, so even the slowest
    // correct run of 1814 requests stays far below the limit.
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     RANDOM_ITEMS  = 1800;
    localparam int     SETTLE_CYCLES = BUFFER_DEPTH + 16;
    localparam stamp_t STAMP_MAX     = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    nearest_timestamp_sample_buffer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow ring: mirrors the sample buffer as requests are accepted.
    // ------------------------------------------------------------------
    req_t ring_entry [BUFFER_DEPTH];
    int   ring_oldest = 0;
    int   ring_fill   = 0;

    // Requests still to be driven, and nearest-sample responses still owed
    req_t request_queue[$];
    rsp_t pending_matches[$];

    int   mismatches    = 0;
    int   stores_seen   = 0;
    int   queries_seen  = 0;
    int   empty_answers = 0;
    int   answers_seen  = 0;
    int   ring_wraps    = 0;
    int   cycle_count   = 0;
    bit   req_taken     = 1'b0;

    // Append a sample; once the ring is full, overwrite the oldest and advance
    function automatic void ring_store(input req_t item);
        idx_t slot;
        if (ring_fill < BUFFER_DEPTH)
        begin
            slot = idx_t'((ring_oldest + ring_fill) % BUFFER_DEPTH);
            ring_fill++;
        end
        else
        begin
            slot        = idx_t'(ring_oldest);
            ring_oldest = (ring_oldest + 1) % BUFFER_DEPTH;
            ring_wraps++;
        end
        ring_entry[slot] = item;
    endfunction

    function automatic stamp_t stamp_distance(input stamp_t a, input stamp_t b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Walk oldest to newest; a strictly smaller distance is needed to replace
    // the current pick, so the oldest of equally near samples is kept
    function automatic rsp_t ring_nearest(input stamp_t target);
        rsp_t   match;
        idx_t   best;
        idx_t   slot;
        int     k;
        stamp_t best_dist;
        stamp_t gap_dist;
        match = '0;
        if (ring_fill == 0)
        begin
            return match;
        end
        best      = idx_t'(ring_oldest);
        best_dist = stamp_distance(ring_entry[best].sample_stamp, target);
        for (k = 1; k < ring_fill; k++)
        begin
            slot     = idx_t'((ring_oldest + k) % BUFFER_DEPTH);
            gap_dist = stamp_distance(ring_entry[slot].sample_stamp, target);
            if (gap_dist < best_dist)
            begin
                best_dist = gap_dist;
                best      = slot;
            end
        end
        match.found       = 1'b1;
        match.match_stamp = ring_entry[best].sample_stamp;
        match.pos_x_out   = ring_entry[best].pos_x_in;
        match.pos_y_out   = ring_entry[best].pos_y_in;
        match.pos_z_out   = ring_entry[best].pos_z_in;
        match.vel_x_out   = ring_entry[best].vel_x_in;
        match.vel_y_out   = ring_entry[best].vel_y_in;
        match.vel_z_out   = ring_entry[best].vel_z_in;
        return match;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic stamp_t wide_stamp();
        return stamp_t'({$urandom(), $urandom()});
    endfunction

    // Pick 0 gives all zeros, 1 all ones, anything else a random pattern
    function automatic word_t motion_word(input int pick);
        case (pick)
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // The query time of a store is ignored by the block: fill it with noise
    function automatic req_t store_item(input stamp_t stamp, input int pick);
        req_t item;
        item.kind         = KIND_STORE;
        item.sample_stamp = stamp;
        item.pos_x_in     = motion_word(pick);
        item.pos_y_in     = motion_word(pick);
        item.pos_z_in     = motion_word(pick);
        item.vel_x_in     = motion_word(pick);
        item.vel_y_in     = motion_word(pick);
        item.vel_z_in     = motion_word(pick);
        item.query_time   = wide_stamp();
        return item;
    endfunction

    // Likewise the sample fields of a query carry noise only
    function automatic req_t query_item(input stamp_t target);
        req_t item;
        item.kind         = KIND_QUERY;
        item.sample_stamp = wide_stamp();
        item.pos_x_in     = $urandom();
        item.pos_y_in     = $urandom();
        item.pos_z_in     = $urandom();
        item.vel_x_in     = $urandom();
        item.vel_y_in     = $urandom();
        item.vel_z_in     = $urandom();
        item.query_time   = target;
        return item;
    endfunction

    // Queue a request at the tail of the pending list
    function automatic void queue_request(input req_t item);
        request_queue.insert(request_queue.size(), item);
    endfunction

    // Sample stream state for the random phase: stamps mostly advance like a
    // real sensor feed, so queries land among held samples and not far outside
    stamp_t stream_now   = stamp_t'(64'd1_000_000);
    stamp_t newest_stamp = '0;
    stamp_t older_stamp  = '0;

    task automatic queue_random(input int count);
        req_t        item;
        stamp_t      stamp;
        logic [63:0] pair_sum;
        int          roll;
        int          n;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                begin
                    // Jump the stream now and then, wrapping at the stamp width
                    if ($urandom_range(0, 199) == 0)
                    begin
                        stream_now = wide_stamp();
                    end
                    stream_now = stream_now + stamp_t'($urandom_range(1, 1500));
                    stamp      = stream_now;
                end
                else if (roll < 90)
                begin
                    stamp = newest_stamp;
                end
                else if (roll < 96)
                begin
                    stamp = wide_stamp();
                end
                else if (roll < 98)
                begin
                    stamp = '0;
                end
                else
                begin
                    stamp = STAMP_MAX;
                end
                older_stamp  = newest_stamp;
                newest_stamp = stamp;
                item = store_item(stamp, $urandom_range(0, 9));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    stamp = stream_now - stamp_t'($urandom_range(0, 100000));
                end
                else if (roll < 60)
                begin
                    stamp = newest_stamp;
                end
                else if (roll < 75)
                begin
                    // Midway between the two latest samples: provokes ties
                    pair_sum = {1'b0, newest_stamp} + {1'b0, older_stamp};
                    stamp    = pair_sum[63:1];
                end
                else if (roll < 90)
                begin
                    stamp = wide_stamp();
                end
                else if (roll < 95)
                begin
                    stamp = '0;
                end
                else
                begin
                    stamp = STAMP_MAX;
                end
                item = query_item(stamp);
            end
            queue_request(item);
        end
    endtask

    // Block until every request is accepted and every response has arrived.
    // Sample at the rising edge: the driver only moves on the falling one.
    task automatic wait_drained();
        while (request_queue.size() != 0 || req_valid || pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them. Hold the
    // request while it is stalled; advance only after it was taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                req_data  <= request_queue[0];
                request_queue.delete(0);
                req_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left = 0;
                    end
                    else
                    begin
                        gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 8);
                    end
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: solid stall runs, then free stretches that are either clean
    // or sprinkled with random stalls.
    // ------------------------------------------------------------------
    int stall_run     = 0;
    int free_run      = 0;
    bit stall_chatter = 1'b0;

    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else if (free_run > 0)
        begin
            free_run--;
            rsp_stall <= stall_chatter && ($urandom_range(0, 2) == 0);
        end
        else
        begin
            stall_run     = $urandom_range(0, 24);
            free_run      = $urandom_range(1, 80);
            stall_chatter = 1'($urandom_range(0, 1));
            rsp_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: update the shadow ring on each accepted request, then match
    // each accepted response against the oldest owed answer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                if (req_data.kind == KIND_STORE)
                begin
                    ring_store(req_data);
                    stores_seen++;
                end
                else
                begin
                    pending_matches.insert(pending_matches.size(),
                                           ring_nearest(req_data.query_time));
                    queries_seen++;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("response with no query outstanding: %p", rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_matches[0];
                    pending_matches.delete(0);
                    answers_seen++;
                    if (!want.found)
                    begin
                        empty_answers++;
                    end
                    check_field("found", 64'(want.found), 64'(rsp_data.found));
                    check_field("match_stamp", 64'(want.match_stamp),
                                64'(rsp_data.match_stamp));
                    check_field("pos_x_out", 64'(want.pos_x_out), 64'(rsp_data.pos_x_out));
                    check_field("pos_y_out", 64'(want.pos_y_out), 64'(rsp_data.pos_y_out));
                    check_field("pos_z_out", 64'(want.pos_z_out), 64'(rsp_data.pos_z_out));
                    check_field("vel_x_out", 64'(want.vel_x_out), 64'(rsp_data.vel_x_out));
                    check_field("vel_y_out", 64'(want.vel_y_out), 64'(rsp_data.vel_y_out));
                    check_field("vel_z_out", 64'(want.vel_z_out), 64'(rsp_data.vel_z_out));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timed out with %0d requests queued and %0d responses owed",
                   request_queue.size(), pending_matches.size());
            $display("FAIL nearest_timestamp_sample_buffer_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: queries on an empty ring, stamp and word extremes,
        // a tie between two samples, and a repeated stamp
        queue_request(query_item('0));
        queue_request(query_item(STAMP_MAX));
        queue_request(store_item('0, 0));
        queue_request(store_item(STAMP_MAX, 1));
        queue_request(query_item('0));
        queue_request(query_item(STAMP_MAX));
        queue_request(query_item(STAMP_MAX >> 1));
        queue_request(query_item(stamp_t'(64'h4000_0000_0000_0000)));
        queue_request(store_item(stamp_t'(64'd100), 2));
        queue_request(store_item(stamp_t'(64'd200), 2));
        queue_request(query_item(stamp_t'(64'd150)));
        queue_request(store_item(stamp_t'(64'd100), 2));
        queue_request(query_item(stamp_t'(64'd100)));
        queue_request(query_item(stamp_t'(64'd99)));

        // Hold the sender off until every answer is back, twice over the run
        wait_drained();
        queue_random(RANDOM_ITEMS / 2);
        wait_drained();
        queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d stores (%0d ring overwrites) and %0d queries.",
                 stores_seen, ring_wraps, queries_seen);
        $display("%0d responses checked, %0d of them from an empty ring; %0d mismatches.",
                 answers_seen, empty_answers, mismatches);
        if (mismatches == 0 && pending_matches.size() == 0)
        begin
            $display("PASS nearest_timestamp_sample_buffer_top");
        end
        else
        begin
            $display("FAIL nearest_timestamp_sample_buffer_top");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ntsb_pkg.sv
rtl/ntsb_ram.sv
rtl/nearest_timestamp_sample_buffer_top.sv
sim/tb_top.sv
